### hw/rtl/shlb_pkg.sv
// Package for the lowbias32 string hash block.
// Holds the shared constants and the command struct used by the controller and datapath.
package shlb_pkg;

  localparam int unsigned LEN_BITS_DEFAULT = 16;
  localparam int unsigned DLEN_W           = 16;
  localparam int unsigned HASH_W           = 32;
  localparam int unsigned BYTE_W           = 8;

  localparam logic [HASH_W-1:0] MIX_MUL_A  = 32'h7feb352d;
  localparam logic [HASH_W-1:0] MIX_MUL_B  = 32'h846ca68b;
  localparam logic [HASH_W-1:0] ZERO_SUBST = 32'h00800800;

  // Input tuser bit positions.
  localparam int unsigned TUSER_FIRST = 0;
  localparam int unsigned TUSER_LAST  = 1;
  localparam int unsigned TUSER_EMPTY = 2;

  // One-hot style commands from the controller to the datapath.
  typedef struct packed {
    logic load_byte;   // add the incoming byte to the running hash
    logic load_empty;  // take an empty-string word
    logic first;       // incoming byte starts a new string
    logic mul_a;       // first multiply of the mixer
    logic mul_b;       // second multiply of the mixer, then final xorshift
    logic xor_len;     // xor the held length into the mixer output
    logic add_len;     // add the held length and replace zero
    logic emit;        // move the result into the output register
  } shlb_cmd_t;

endpackage

### hw/rtl/string_hash_lowbias.sv
// Top level of the lowbias32 string hash block.
// Joins shlb_ctrl and shlb_dpath; uses shlb_pkg.
//
// The block hashes a byte string that arrives one word per byte on the
// slave stream. The first word of a string carries the declared length,
// which seeds the hash; every byte is added as a sign-extended signed char
// and then mixed by the lowbias32 xorshift-multiply function. After the last
// byte the length is xored in, the hash is mixed once more and the length
// is added; a zero result is replaced by 0x800800. An empty-string word
// yields the hash of length zero at once. The result word also flags a byte
// count that differs from the declared length (the count saturates at the
// top of its LENGTH_BITS range). A single 32x32 multiplier is shared by both
// multiplies of the mixer, so each byte is added first and then runs each
// multiply in its own step; no new word is taken until these are done.
// The last byte adds the final mix and length add and then the result load;
// an empty-string word goes straight to the load. The result sits in an
// output register, so the next string can start while it waits to be taken.
module string_hash_lowbias
  import shlb_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LEN_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] declared_length
  input  logic [2:0]  s_axis_tuser,   // [0] first_of_string, [1] last_of_string,
                                      // [2] empty_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] hash_value
  output logic [0:0]  m_axis_tuser    // [0] length_mismatch
);

  shlb_cmd_t cmd;
  logic      mismatch;

  // The controller decides when words are taken and which step runs.
  shlb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_first_i  (s_axis_tuser[TUSER_FIRST]),
    .in_last_i   (s_axis_tuser[TUSER_LAST]),
    .in_empty_i  (s_axis_tuser[TUSER_EMPTY]),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // The datapath holds the running hash, the length and the byte count.
  shlb_dpath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .data_byte_i       (s_axis_tdata[7:0]),
    .declared_length_i (s_axis_tdata[23:8]),
    .hash_value_o      (m_axis_tdata),
    .length_mismatch_o (mismatch)
  );

  assign m_axis_tuser[0] = mismatch;

endmodule

### hw/rtl/shlb_ctrl.sv
// Controller of the lowbias32 string hash block.
// Sequences the shared multiplier and the output register; uses shlb_pkg.
module shlb_ctrl
  import shlb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_first_i,
  input  logic      in_last_i,
  input  logic      in_empty_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output shlb_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_FIN_A,
    ST_FIN_B,
    ST_FIN_ADD,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   last_q, last_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_empty_i) begin
            cmd_o.load_empty = 1'b1;
            state_d          = ST_EMIT;
          end else begin
            cmd_o.load_byte = 1'b1;
            cmd_o.first     = in_first_i;
            last_d          = in_last_i;
            state_d         = ST_MUL_A;
          end
        end
      end
      ST_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul_b   = 1'b1;
        cmd_o.xor_len = last_q;
        state_d       = last_q ? ST_FIN_A : ST_IDLE;
      end
      ST_FIN_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = ST_FIN_B;
      end
      ST_FIN_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_FIN_ADD;
      end
      ST_FIN_ADD: begin
        cmd_o.add_len = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          last_d     = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The output register is loaded only when it is empty or being drained.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  // The datapath never gets two operations in one cycle.
  a_cmd_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_byte, cmd_o.load_empty, cmd_o.mul_a, cmd_o.mul_b,
              cmd_o.add_len, cmd_o.emit}))
    else $error("more than one datapath operation in a cycle");

  // An accepted word always starts work, so the next word waits.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("input ready right after an accepted word");

endmodule

### hw/rtl/shlb_dpath.sv
// Datapath of the lowbias32 string hash block: running hash, length and byte
// count registers, one shared 32x32 multiplier and the output register; uses shlb_pkg.
module shlb_dpath
  import shlb_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LEN_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  shlb_cmd_t         cmd_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [DLEN_W-1:0] declared_length_i,
  output logic [HASH_W-1:0] hash_value_o,
  output logic              length_mismatch_o
);

  localparam int unsigned CW = (LENGTH_BITS < DLEN_W) ? LENGTH_BITS : DLEN_W;
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

  logic [HASH_W-1:0]      hash_q, hash_d;
  logic [LENGTH_BITS-1:0] held_q, held_d;
  logic [LENGTH_BITS-1:0] seen_q, seen_d;
  logic [HASH_W-1:0]      out_hash_q;
  logic                   out_mis_q;

  logic [LENGTH_BITS-1:0] dlen;
  logic [HASH_W-1:0]      len_ext;
  logic [HASH_W-1:0]      byte_ext;
  logic [HASH_W-1:0]      base_hash;
  logic [LENGTH_BITS-1:0] base_seen;
  logic [HASH_W-1:0]      mul_in;
  logic [HASH_W-1:0]      mul_k;
  logic [HASH_W-1:0]      prod;
  logic [HASH_W-1:0]      mixed;
  logic [HASH_W-1:0]      sum;

  assign dlen     = LENGTH_BITS'(declared_length_i[CW-1:0]);
  assign len_ext  = HASH_W'(held_q);
  assign byte_ext = {{(HASH_W-BYTE_W){data_byte_i[BYTE_W-1]}}, data_byte_i};

  assign base_hash = cmd_i.first ? HASH_W'(dlen) : hash_q;
  assign base_seen = cmd_i.first ? '0 : seen_q;

  // Shared multiplier: the pre-shift differs between the two mixer steps.
  assign mul_in = cmd_i.mul_a ? (hash_q ^ (hash_q >> 16)) : (hash_q ^ (hash_q >> 15));
  assign mul_k  = cmd_i.mul_a ? MIX_MUL_A : MIX_MUL_B;
  assign prod   = mul_in * mul_k;
  assign mixed  = prod ^ (prod >> 16);
  assign sum    = hash_q + len_ext;

  always_comb begin
    hash_d = hash_q;
    held_d = held_q;
    seen_d = seen_q;
    if (cmd_i.load_byte) begin
      hash_d = base_hash + byte_ext;
      if (cmd_i.first) begin
        held_d = dlen;
      end
      seen_d = (base_seen < COUNT_MAX) ? base_seen + 1'b1 : base_seen;
    end
    if (cmd_i.load_empty) begin
      hash_d = ZERO_SUBST;
      held_d = dlen;
      seen_d = '0;
    end
    if (cmd_i.mul_a) begin
      hash_d = prod;
    end
    if (cmd_i.mul_b) begin
      hash_d = cmd_i.xor_len ? (mixed ^ len_ext) : mixed;
    end
    if (cmd_i.add_len) begin
      hash_d = (sum == '0) ? ZERO_SUBST : sum;
    end
    if (cmd_i.emit) begin
      hash_d = '0;
      held_d = '0;
      seen_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      held_q <= '0;
      seen_q <= '0;
    end else begin
      hash_q <= hash_d;
      held_q <= held_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_hash_q <= hash_q;
      out_mis_q  <= (seen_q != held_q);
    end
  end

  assign hash_value_o      = out_hash_q;
  assign length_mismatch_o = out_mis_q;

  // A byte always leaves a nonzero count behind it.
  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_byte |=> (seen_q != '0))
    else $error("byte count zero after a byte");

endmodule

### tb/sv/string_hash_lowbias_check.sv
// Checker for the lowbias32 string hash block: watches both stream channels,
// predicts every hash word and compares it with what the block delivers.
// Depends on shlb_pkg for the mixer constants and the tuser bit positions.
module string_hash_lowbias_check
  import shlb_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LEN_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,    // [7:0] data_byte, [23:8] declared_length
  input  logic [2:0]  s_tuser_i,    // [0] first_of_string, [1] last_of_string,
                                    // [2] empty_string
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,    // [31:0] hash_value
  input  logic [0:0]  m_tuser_i,    // [0] length_mismatch
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic              mismatch;
  } hash_word_t;

  hash_word_t  expected_hashes[$];
  logic [31:0] run_hash;
  logic [31:0] held_len;
  logic [31:0] byte_count;
  int          fail_count;
  int          pending;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  initial begin
    fail_count = 0;
    pending    = 0;
    run_hash   = '0;
    held_len   = '0;
    byte_count = '0;
  end

  function automatic logic [31:0] lowbias_mix(input logic [31:0] v);
    logic [31:0] h;
    h = v;
    h = h ^ (h >> 16);
    h = h * MIX_MUL_A;
    h = h ^ (h >> 15);
    h = h * MIX_MUL_B;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic logic [31:0] lowbias_finish(input logic [31:0] v, input logic [31:0] len);
    logic [31:0] h;
    h = lowbias_mix(v ^ len) + len;
    if (h == '0) h = ZERO_SUBST;
    return h;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    hash_word_t  want;
    logic [7:0]  data_byte;
    logic [31:0] dlen;
    if (!rst_ni) begin
      run_hash   = '0;
      held_len   = '0;
      byte_count = '0;
    end else begin
      // Results are checked before this edge's input word is predicted, so a
      // result that arrives with nothing waiting can never be masked.
      if (m_tvalid_i && m_tready_i) begin
        if (expected_hashes.size() == 0) begin
          report_mismatch("hash word with nothing pending", m_tdata_i, '0);
        end else begin
          want = expected_hashes.pop_front();
          if (m_tdata_i !== want.hash)
            report_mismatch("hash_value", m_tdata_i, want.hash);
          if (m_tuser_i[0] !== want.mismatch)
            report_mismatch("length_mismatch", 32'(m_tuser_i[0]), 32'(want.mismatch));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        data_byte = s_tdata_i[7:0];
        dlen      = 32'(s_tdata_i[23:8]) & LEN_MASK;
        if (s_tuser_i[TUSER_EMPTY]) begin
          // An empty string wins over the other flags and drops any open string.
          want.hash     = lowbias_finish('0, '0);
          want.mismatch = (dlen != '0);
          expected_hashes.push_back(want);
          run_hash   = '0;
          held_len   = '0;
          byte_count = '0;
        end else begin
          if (s_tuser_i[TUSER_FIRST]) begin
            run_hash   = dlen;
            held_len   = dlen;
            byte_count = '0;
          end
          run_hash = lowbias_mix(run_hash + {{24{data_byte[7]}}, data_byte});
          if (byte_count != LEN_MASK) byte_count = byte_count + 1;
          if (s_tuser_i[TUSER_LAST]) begin
            want.hash     = lowbias_finish(run_hash, held_len);
            want.mismatch = (byte_count != held_len);
            expected_hashes.push_back(want);
            run_hash   = '0;
            held_len   = '0;
            byte_count = '0;
          end
        end
      end
    end
    pending = expected_hashes.size();
  end

endmodule

### tb/sv/string_hash_lowbias_test.sv
// Top of the string hash testbench: clock, reset, stimulus, receiver and verdict.
// Instantiates string_hash_lowbias and string_hash_lowbias_check; uses shlb_pkg.
module string_hash_lowbias_test
  import shlb_pkg::*;
();

  // A cycle without any accepted word on either side counts toward the
  // watchdog. The worst legal quiet stretch is the receiver hold-off plus the
  // sender gaps and the mixing, so this limit leaves a wide margin.
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned RANDOM_WORDS    = 800;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned HOLD_OFF_AFTER  = 40;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [23:0] s_axis_tdata  = '0;   // [7:0] data_byte, [23:8] declared_length
  logic [2:0]  s_axis_tuser  = '0;   // [0] first_of_string, [1] last_of_string,
                                     // [2] empty_string
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;         // [31:0] hash_value
  logic [0:0]  m_axis_tuser;         // [0] length_mismatch

  int fail_count;
  int pending_hashes;
  int words_in     = 0;
  int hashes_out   = 0;
  int idle_cycles  = 0;
  bit gapless_tx   = 1'b0;
  bit gapless_rx   = 1'b0;
  bit held_off     = 1'b0;

  string_hash_lowbias DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  string_hash_lowbias_check hash_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending_hashes)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Word counters and the watchdog. Any accepted word on either side resets
  // the idle count; reaching the limit means the block has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) words_in++;
      if (m_axis_tvalid && m_axis_tready) hashes_out++;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no word accepted for %0d cycles.", IDLE_LIMIT);
        $display("string_hash_lowbias_test failed");
        $finish;
      end
    end
  end

  // Offers one input word after a random gap and holds it until accepted.
  // All changes happen at the falling edge; valid is only lowered when a
  // gap is drawn, so back-to-back words keep it high without a glitch.
  task automatic send_word(input logic [7:0] data_byte, input logic [15:0] dlen,
                           input logic first, input logic last, input logic empty);
    int          gap;
    logic [2:0]  flags;
    gap = gapless_tx ? 0 : $urandom_range(0, 7);
    flags              = '0;
    flags[TUSER_FIRST] = first;
    flags[TUSER_LAST]  = last;
    flags[TUSER_EMPTY] = empty;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {dlen, data_byte};
    s_axis_tuser  <= flags;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  // A well-formed string of n bytes: first on the opening byte, last on the
  // closing one. The length field of later bytes is noise the block ignores.
  task automatic send_string(input int n, input logic [15:0] dlen);
    for (int k = 0; k < n; k++) begin
      send_word(8'($urandom_range(0, 255)), (k == 0) ? dlen : 16'($urandom()),
                k == 0, k == n - 1, 1'b0);
    end
  endtask

  // Waits at least one falling edge, then until every predicted hash has
  // been delivered.
  task automatic drain_hashes();
    do @(negedge clk_i); while (pending_hashes != 0);
  endtask

  // Receiver: a random wait before each hash word, stretches of constant
  // readiness, and one long hold-off that lets the block back up into its
  // input while the sender keeps offering words.
  initial begin
    int wait_cycles;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) gapless_rx = !gapless_rx;
      wait_cycles = gapless_rx ? 0 : $urandom_range(0, 7);
      if (!held_off && hashes_out >= HOLD_OFF_AFTER) begin
        wait_cycles = HOLD_OFF_CYCLES;
        held_off    = 1'b1;
      end
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  // Stimulus: directed corner cases, a full drain, and the random mix of
  // strings, empty strings and noise.
  initial begin
    int kind;
    int n;
    int random_start;
    logic [15:0] dlen;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty strings, with a zero and a full declared length. The second one
    // also carries first and last and a byte, which the empty flag overrides.
    send_word(8'h00, 16'h0000, 1'b0, 1'b0, 1'b1);
    send_word(8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    // One-byte strings at both byte extremes.
    send_word(8'h00, 16'h0001, 1'b1, 1'b1, 1'b0);
    send_word(8'hFF, 16'h0001, 1'b1, 1'b1, 1'b0);
    // A last byte with no first: it runs on from the cleared state, so the
    // declared length is zero and the count of one is flagged.
    send_word(8'h80, 16'hFFFF, 1'b0, 1'b1, 1'b0);
    // Bytes on both sides of the sign boundary.
    send_word(8'h7F, 16'h0003, 1'b1, 1'b0, 1'b0);
    send_word(8'h80, 16'h5A5A, 1'b0, 1'b0, 1'b0);
    send_word(8'h01, 16'hA5A5, 1'b0, 1'b1, 1'b0);
    // The largest declared length with only two bytes behind it.
    send_word(8'hAA, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_word(8'h55, 16'h0000, 1'b0, 1'b1, 1'b0);
    // A declared length of zero on a one-byte string.
    send_word(8'h3C, 16'h0000, 1'b1, 1'b1, 1'b0);
    // An empty string in the middle of an open string drops it; the byte
    // that follows carries on from the cleared state.
    send_word(8'h11, 16'h0005, 1'b1, 1'b0, 1'b0);
    send_word(8'h22, 16'h0000, 1'b0, 1'b0, 1'b0);
    send_word(8'h33, 16'h0007, 1'b0, 1'b0, 1'b1);
    send_word(8'h44, 16'h0000, 1'b0, 1'b1, 1'b0);
    // A second first restarts the string.
    send_word(8'hC0, 16'h0002, 1'b1, 1'b0, 1'b0);
    send_word(8'hC1, 16'h0002, 1'b1, 1'b0, 1'b0);
    send_word(8'hC2, 16'h0000, 1'b0, 1'b1, 1'b0);

    // The sender stops until every hash is out before the random part.
    s_axis_tvalid <= 1'b0;
    drain_hashes();

    random_start = words_in;
    while (words_in < random_start + RANDOM_WORDS) begin
      kind       = $urandom_range(0, 99);
      gapless_tx = ($urandom_range(0, 3) == 0);
      if (kind < 72) begin
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        dlen = 16'(n);
        if ($urandom_range(0, 5) == 0) dlen = 16'($urandom());
        send_string(n, dlen);
      end else if (kind < 84) begin
        dlen = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom());
        send_word(8'($urandom()), dlen, 1'($urandom()), 1'($urandom()), 1'b1);
      end else begin
        // Noise: arbitrary flags and data, including broken strings.
        repeat ($urandom_range(1, 4)) begin
          send_word(8'($urandom()), 16'($urandom()), 1'($urandom()), 1'($urandom()),
                    1'($urandom()));
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    drain_hashes();
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d input words and %0d hash words: corner cases, random strings,",
             words_in, hashes_out);
    $display("empty strings, broken strings as noise and a %0d-cycle receiver hold-off.",
             HOLD_OFF_CYCLES);
    if (fail_count == 0) begin
      $display("string_hash_lowbias_test passed");
    end else begin
      $display("string_hash_lowbias_test failed");
    end
    $finish;
  end

endmodule
